// ===== rtl/pgc_pkg.sv =====
// shared types and constants for the proximity gesture classifier
// no dependencies
`timescale 1ns / 1ps

package pgc_pkg;

	localparam int TimeW   = 32;
	localparam int StampW  = 32;
	localparam int SampleW = 16;
	localparam int DistW   = 12;
	localparam int SlackW  = 10;
	localparam int WaitW   = 16;
	localparam int CodeW   = 3;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [SampleW-1:0] DistLimit = SampleW'(4000);
	localparam logic [DistW-1:0]   DistFar   = DistW'(999);

	localparam logic [CodeW-1:0] GestNone      = 3'd0;
	localparam logic [CodeW-1:0] GestPress     = 3'd1;
	localparam logic [CodeW-1:0] GestCircle    = 3'd2;
	localparam logic [CodeW-1:0] GestSwipeDown = 3'd3;
	localparam logic [CodeW-1:0] GestSwipeUp   = 3'd4;

	localparam logic [CfgIdxW-1:0] RegPressThr   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegNearThr    = 3'd1;
	localparam logic [CfgIdxW-1:0] RegFarThr     = 3'd2;
	localparam logic [CfgIdxW-1:0] RegDebounce   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegCooldown   = 3'd4;
	localparam logic [CfgIdxW-1:0] RegCircleMgn  = 3'd5;
	localparam logic [CfgIdxW-1:0] RegSwipeDelta = 3'd6;

	typedef struct packed {
		logic [DistW-1:0]  press_thr;
		logic [DistW-1:0]  near_thr;
		logic [DistW-1:0]  far_thr;
		logic [WaitW-1:0]  debounce_ms;
		logic [WaitW-1:0]  cooldown_ms;
		logic [SlackW-1:0] circle_margin;
		logic [SlackW-1:0] swipe_delta;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		press_thr:     DistW'(80),
		near_thr:      DistW'(150),
		far_thr:       DistW'(300),
		debounce_ms:   WaitW'(400),
		cooldown_ms:   WaitW'(300),
		circle_margin: SlackW'(30),
		swipe_delta:   SlackW'(20)
	};

endpackage

// ===== rtl/pgc_if.sv =====
// valid/ready channels for samples and gesture results
// depends on pgc_pkg
`timescale 1ns / 1ps

interface pgc_sample_if;
	logic                        valid;
	logic                        ready;
	logic [pgc_pkg::SampleW-1:0] sample_mm;
	logic                        timed_out;
	logic [pgc_pkg::StampW-1:0]  now_ms;

	modport source (output valid, output sample_mm, output timed_out, output now_ms,
		input ready);
	modport sink (input valid, input sample_mm, input timed_out, input now_ms,
		output ready);
endinterface

interface pgc_gesture_if;
	logic                      valid;
	logic                      ready;
	logic [pgc_pkg::CodeW-1:0] gesture_code;

	modport source (output valid, output gesture_code, input ready);
	modport sink (input valid, input gesture_code, output ready);
endinterface

// ===== rtl/pgc_cfg_regs.sv =====
// configuration register bank, written by index
// depends on pgc_pkg
`timescale 1ns / 1ps

module pgc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pgc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pgc_pkg::CfgDataW-1:0] cfg_wdata,
	output pgc_pkg::cfg_t                cfg
);

	pgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pgc_pkg::CfgReset;
		end else if (cfg_we) begin
			case (cfg_index)
				pgc_pkg::RegPressThr:   cfg_q.press_thr     <= cfg_wdata[pgc_pkg::DistW-1:0];
				pgc_pkg::RegNearThr:    cfg_q.near_thr      <= cfg_wdata[pgc_pkg::DistW-1:0];
				pgc_pkg::RegFarThr:     cfg_q.far_thr       <= cfg_wdata[pgc_pkg::DistW-1:0];
				pgc_pkg::RegDebounce:   cfg_q.debounce_ms   <= cfg_wdata[pgc_pkg::WaitW-1:0];
				pgc_pkg::RegCooldown:   cfg_q.cooldown_ms   <= cfg_wdata[pgc_pkg::WaitW-1:0];
				pgc_pkg::RegCircleMgn:  cfg_q.circle_margin <= cfg_wdata[pgc_pkg::SlackW-1:0];
				pgc_pkg::RegSwipeDelta: cfg_q.swipe_delta   <= cfg_wdata[pgc_pkg::SlackW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/pgc_core.sv =====
// input register, gesture decision logic with its history state, result register
// depends on pgc_pkg and the channel interfaces in pgc_if
`timescale 1ns / 1ps

module pgc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  pgc_pkg::cfg_t cfg,
	pgc_sample_if.sink    sample_ch,
	pgc_gesture_if.source gesture_ch
);

	localparam int SumW = pgc_pkg::DistW + 1;

	logic                        valid_s1;
	logic [pgc_pkg::DistW-1:0]   dist_s1;
	logic [pgc_pkg::TimeW-1:0]   now_s1;
	logic                        out_valid_q;
	logic [pgc_pkg::CodeW-1:0]   gesture_q;

	logic [pgc_pkg::DistW-1:0]   prev_dist_q;
	logic                        prev_near_q;
	logic [pgc_pkg::TimeW-1:0]   press_time_q;
	logic [pgc_pkg::TimeW-1:0]   gesture_time_q;

	logic                        accept;
	logic                        advance;
	logic [pgc_pkg::DistW-1:0]   dist_in;
	logic                        is_near;
	logic                        is_press;
	logic [pgc_pkg::TimeW-1:0]   press_age;
	logic [pgc_pkg::TimeW-1:0]   gesture_age;
	logic                        press_hit;
	logic                        cool_ok;
	logic [SumW-1:0]             circle_bound;
	logic [SumW-1:0]             down_bound;
	logic [SumW-1:0]             up_bound;
	logic                        want;
	logic [pgc_pkg::CodeW-1:0]   cand;
	logic [pgc_pkg::CodeW-1:0]   code;

	// stage 1 moves on when the result register is free or being drained
	assign advance = valid_s1 && (!out_valid_q || gesture_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;
	assign accept = sample_ch.valid && sample_ch.ready;

	// out-of-range or timed-out readings read as far away
	assign dist_in = (sample_ch.timed_out || sample_ch.sample_mm > pgc_pkg::DistLimit)
		? pgc_pkg::DistFar : sample_ch.sample_mm[pgc_pkg::DistW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dist_s1 <= dist_in;
			now_s1  <= pgc_pkg::TimeW'(sample_ch.now_ms);
		end
	end

	// decision
	assign is_near  = dist_s1 < cfg.near_thr;
	assign is_press = dist_s1 < cfg.press_thr;

	assign press_age   = now_s1 - press_time_q;
	assign gesture_age = now_s1 - gesture_time_q;
	assign press_hit   = is_press && (press_age > pgc_pkg::TimeW'(cfg.debounce_ms));
	assign cool_ok     = gesture_age >= pgc_pkg::TimeW'(cfg.cooldown_ms);

	assign circle_bound = SumW'(cfg.press_thr) + SumW'(cfg.circle_margin);
	assign down_bound   = SumW'(dist_s1) + SumW'(cfg.swipe_delta);
	assign up_bound     = SumW'(prev_dist_q) + SumW'(cfg.swipe_delta);

	always_comb begin
		want = 1'b0;
		cand = pgc_pkg::GestNone;
		if (press_hit) begin
			want = 1'b1;
			cand = pgc_pkg::GestPress;
		end else if (prev_near_q && !is_near && prev_dist_q < cfg.near_thr) begin
			if (SumW'(prev_dist_q) < circle_bound) begin
				want = 1'b1;
				cand = pgc_pkg::GestCircle;
			end
		end else if (is_near && prev_dist_q > cfg.far_thr) begin
			if (SumW'(prev_dist_q) > down_bound) begin
				want = 1'b1;
				cand = pgc_pkg::GestSwipeDown;
			end else if (SumW'(dist_s1) > up_bound) begin
				want = 1'b1;
				cand = pgc_pkg::GestSwipeUp;
			end
		end
		code = (want && cool_ok) ? cand : pgc_pkg::GestNone;
	end

	// history, updated once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dist_q    <= pgc_pkg::DistFar;
			prev_near_q    <= 1'b0;
			press_time_q   <= '0;
			gesture_time_q <= '0;
		end else if (advance) begin
			prev_dist_q <= dist_s1;
			prev_near_q <= is_near;
			if (press_hit) begin
				press_time_q <= now_s1;
			end
			if (want && cool_ok) begin
				gesture_time_q <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (gesture_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_q <= code;
		end
	end

	assign gesture_ch.valid        = out_valid_q;
	assign gesture_ch.gesture_code = gesture_q;

endmodule

// ===== rtl/proximity_gesture_classifier.sv =====
// Proximity gesture classifier: takes one distance sample per transaction and returns
// one gesture code for it (none, press, circle, swipe down, swipe up). A new sample is
// accepted every cycle while gesture_ch is ready; it goes to the input register, its code
// to the result register, and the decision is a single pass of compares and adds between
// those two registers. The user must write configuration through cfg_we, cfg_index and
// cfg_wdata only while no transaction is in flight; the block itself does not enforce it.
// depends on pgc_pkg, pgc_if, pgc_cfg_regs and pgc_core
`timescale 1ns / 1ps

module proximity_gesture_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	pgc_sample_if.sink                   sample_ch,
	pgc_gesture_if.source                gesture_ch,
	input  logic                         cfg_we,
	input  logic [pgc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pgc_pkg::CfgDataW-1:0] cfg_wdata
);

	pgc_pkg::cfg_t cfg;

	pgc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pgc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.sample_ch  (sample_ch),
		.gesture_ch (gesture_ch)
	);

endmodule

// ===== dv/pgc_gesture_checker.sv =====
// gesture checker: predicts the code for every accepted sample and compares each
// returned gesture transaction in order; depends on pgc_pkg and pgc_if
`timescale 1ns / 1ps

module pgc_gesture_checker
	import pgc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	pgc_sample_if               sample_ch,
	pgc_gesture_if              gesture_ch,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output int                  mismatch_count,
	output int                  codes_owed
);

	cfg_t             cfg_shadow;
	logic [DistW-1:0] last_dist;
	logic             last_near;
	logic [TimeW-1:0] last_press;
	logic [TimeW-1:0] last_gesture;
	logic [CodeW-1:0] expected_codes[$];

	function automatic logic [CodeW-1:0] cooled(input logic [TimeW-1:0] t,
		input logic [CodeW-1:0] g);
		if (TimeW'(t - last_gesture) < cfg_shadow.cooldown_ms)
			return GestNone;
		last_gesture = t;
		return g;
	endfunction

	function automatic logic [CodeW-1:0] classify_sample(input logic [SampleW-1:0] mm,
		input logic tmo, input logic [StampW-1:0] stamp);
		int               d;
		int               prev;
		logic             near_now;
		logic             press_now;
		logic [TimeW-1:0] t;
		logic [CodeW-1:0] g;
		t = stamp[TimeW-1:0];
		d = (tmo || mm > DistLimit) ? int'(DistFar) : int'(mm);
		prev = int'(last_dist);
		near_now = d < int'(cfg_shadow.near_thr);
		press_now = d < int'(cfg_shadow.press_thr);
		g = GestNone;
		if (press_now && TimeW'(t - last_press) > cfg_shadow.debounce_ms) begin
			// press time moves on even if the cooldown swallows the press
			last_press = t;
			g = cooled(t, GestPress);
		end else if (last_near && !near_now && prev < int'(cfg_shadow.near_thr)) begin
			if (prev < int'(cfg_shadow.press_thr) + int'(cfg_shadow.circle_margin))
				g = cooled(t, GestCircle);
		end else if (near_now && prev > int'(cfg_shadow.far_thr)) begin
			if (prev > d + int'(cfg_shadow.swipe_delta))
				g = cooled(t, GestSwipeDown);
			else if (d > prev + int'(cfg_shadow.swipe_delta))
				g = cooled(t, GestSwipeUp);
		end
		last_near = near_now;
		last_dist = DistW'(d);
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [CodeW-1:0] want;
		if (!arst_n) begin
			cfg_shadow = CfgReset;
			last_dist = DistFar;
			last_near = 1'b0;
			last_press = '0;
			last_gesture = '0;
			expected_codes.delete();
			mismatch_count = 0;
			codes_owed = 0;
		end else begin
			if (gesture_ch.valid && gesture_ch.ready) begin
				if (expected_codes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected gesture transaction: actual %0d",
							gesture_ch.gesture_code);
				end else begin
					want = expected_codes.pop_front();
					if (gesture_ch.gesture_code !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("gesture code: expected %0d, actual %0d",
								want, gesture_ch.gesture_code);
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready)
				expected_codes.push_back(classify_sample(sample_ch.sample_mm,
					sample_ch.timed_out, sample_ch.now_ms));
			if (cfg_we) begin
				case (cfg_index)
					RegPressThr:   cfg_shadow.press_thr = cfg_wdata[DistW-1:0];
					RegNearThr:    cfg_shadow.near_thr = cfg_wdata[DistW-1:0];
					RegFarThr:     cfg_shadow.far_thr = cfg_wdata[DistW-1:0];
					RegDebounce:   cfg_shadow.debounce_ms = cfg_wdata[WaitW-1:0];
					RegCooldown:   cfg_shadow.cooldown_ms = cfg_wdata[WaitW-1:0];
					RegCircleMgn:  cfg_shadow.circle_margin = cfg_wdata[SlackW-1:0];
					RegSwipeDelta: cfg_shadow.swipe_delta = cfg_wdata[SlackW-1:0];
					default: ;
				endcase
			end
			codes_owed = expected_codes.size();
		end
	end

endmodule

// ===== dv/tb_proximity_gesture_classifier.sv =====
// top of the gesture classifier bench: directed and random sample streams over several
// register settings, random idles on both channels; depends on pgc_pkg, pgc_if, the
// classifier and pgc_gesture_checker
`timescale 1ns / 1ps

module tb_proximity_gesture_classifier;
	import pgc_pkg::*;

	typedef enum int {MovePress, MoveCircle, MoveSwipe, MoveRise, MoveCreep, MoveNoise} motion_e;

	localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
	localparam int HoldCycles = 300;
	localparam int PhaseItems = 160;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;
	logic                hold_req = 1'b0;
	logic                quiet = 1'b0;
	int                  mismatch_count;
	int                  codes_owed;
	int                  sent;
	cfg_t                cur;
	logic [StampW-1:0]   stamp;

	pgc_sample_if  sample_ch();
	pgc_gesture_if gesture_ch();

	proximity_gesture_classifier u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_ch  (sample_ch),
		.gesture_ch (gesture_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	pgc_gesture_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_ch      (sample_ch),
		.gesture_ch     (gesture_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.codes_owed     (codes_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SampleW-1:0] pick_mm(input int lo, input int hi);
		if (lo < 0)
			lo = 0;
		if (hi < lo)
			hi = lo;
		return SampleW'($urandom_range(hi, lo));
	endfunction

	function automatic logic [StampW-1:0] stride();
		case ($urandom_range(9))
			0: return '0;
			7, 8: return $urandom_range(700, 250);
			9: return $urandom_range(70000, 0);
			default: return $urandom_range(250, 1);
		endcase
	endfunction

	function automatic cfg_t roll_cfg();
		cfg_t c;
		c.press_thr = DistW'($urandom_range(300));
		c.near_thr = DistW'(c.press_thr + $urandom_range(400));
		c.far_thr = DistW'($urandom_range(900, 50));
		c.debounce_ms = WaitW'($urandom_range(700));
		c.cooldown_ms = WaitW'($urandom_range(700));
		c.circle_margin = SlackW'($urandom_range(($urandom_range(3) == 0) ? 1023 : 80));
		c.swipe_delta = SlackW'($urandom_range(120));
		return c;
	endfunction

	task automatic offer(input logic [SampleW-1:0] mm, input logic tmo,
		input logic [StampW-1:0] at);
		if (!quiet && $urandom_range(99) < 16) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		stamp = at;
		sample_ch.valid <= 1'b1;
		sample_ch.sample_mm <= mm;
		sample_ch.timed_out <= tmo;
		sample_ch.now_ms <= at;
		do @(posedge clk); while (!sample_ch.ready);
		sent++;
	endtask

	task automatic offer_next(input logic [SampleW-1:0] mm, input logic tmo);
		offer(mm, tmo, stamp + stride());
	endtask

	// short gesture-like sequences with random content, plus raw noise
	task automatic motion();
		int p;
		int band;
		band = int'(cur.press_thr) + int'(cur.circle_margin);
		if (band > int'(cur.near_thr))
			band = int'(cur.near_thr);
		p = int'(cur.far_thr) + 1 + $urandom_range(60);
		case (motion_e'($urandom_range(5)))
			MovePress:
				repeat ($urandom_range(4, 1))
					offer_next(pick_mm(0, int'(cur.press_thr) - 1), 1'b0);
			MoveCircle: begin
				repeat ($urandom_range(3, 1))
					offer_next(pick_mm(int'(cur.press_thr), band - 1), 1'b0);
				offer_next(pick_mm(int'(cur.near_thr), int'(cur.near_thr) + 300), 1'b0);
			end
			MoveSwipe: begin
				if ($urandom_range(3) == 0)
					offer_next(pick_mm(4001, 65535), 1'($urandom_range(1)));
				else
					offer_next(pick_mm(int'(cur.far_thr) + 1, 4000), 1'b0);
				offer_next(pick_mm(0, int'(cur.near_thr) - 1), 1'b0);
			end
			MoveRise: begin
				offer_next(SampleW'(p), 1'b0);
				offer_next(pick_mm(p + int'(cur.swipe_delta) - 2, int'(cur.near_thr) - 1), 1'b0);
			end
			MoveCreep: begin
				offer_next(SampleW'(p), 1'b0);
				offer_next(pick_mm(p - int'(cur.swipe_delta) - 1,
					p + int'(cur.swipe_delta) + 1), 1'b0);
			end
			default:
				repeat ($urandom_range(3, 1))
					offer_next($urandom_range(1) ? SampleW'($urandom) : pick_mm(0, 1200),
						$urandom_range(7) == 0);
		endcase
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (codes_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// upper bits above the distance and slack register widths carry junk
	task automatic load_settings(input cfg_t c);
		put_reg(RegSpare, CfgDataW'($urandom));
		put_reg(RegPressThr, {(CfgDataW - DistW)'($urandom), c.press_thr});
		put_reg(RegNearThr, {(CfgDataW - DistW)'($urandom), c.near_thr});
		put_reg(RegFarThr, {(CfgDataW - DistW)'($urandom), c.far_thr});
		put_reg(RegDebounce, c.debounce_ms);
		put_reg(RegCooldown, c.cooldown_ms);
		put_reg(RegCircleMgn, {(CfgDataW - SlackW)'($urandom), c.circle_margin});
		put_reg(RegSwipeDelta, {(CfgDataW - SlackW)'($urandom), c.swipe_delta});
		cfg_we <= 1'b0;
		cur = c;
	endtask

	initial begin
		gesture_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				gesture_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end
			gesture_ch.ready <= quiet || ($urandom_range(99) >= 16);
		end
	end

	initial begin
		cfg_t rise;
		cfg_t plan [7];
		int   goal;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_mm = '0;
		sample_ch.timed_out = 1'b0;
		sample_ch.now_ms = '0;
		cur = CfgReset;
		stamp = '0;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: debounce at start, debounce edge, suppressed press,
		// circle and failed circle, swipe down, timeout and range limits
		offer(16'd0, 1'b0, 32'd0);
		offer(16'd50, 1'b0, 32'd500);
		offer(16'd50, 1'b0, 32'd600);
		offer(16'd50, 1'b0, 32'd900);
		offer(16'd50, 1'b0, 32'd901);
		offer(16'd100, 1'b0, 32'd2000);
		offer(16'd200, 1'b0, 32'd2100);
		offer(16'd10, 1'b0, 32'd2150);
		offer(16'd10, 1'b0, 32'd2300);
		offer(16'd120, 1'b0, 32'd3000);
		offer(16'd500, 1'b0, 32'd3100);
		offer(16'd100, 1'b0, 32'd3500);
		offer(16'd60, 1'b1, 32'd4000);
		offer(16'd4000, 1'b0, 32'd4500);
		offer(16'd100, 1'b0, 32'd5000);
		offer(16'd4001, 1'b0, 32'd5600);
		offer(16'd65535, 1'b0, 32'd6000);
		offer(16'd130, 1'b0, 32'd7000);

		// near above far: swipe up, small change, zero debounce and cooldown
		rise.press_thr = DistW'(100);
		rise.near_thr = DistW'(600);
		rise.far_thr = DistW'(300);
		rise.debounce_ms = '0;
		rise.cooldown_ms = '0;
		rise.circle_margin = '0;
		rise.swipe_delta = SlackW'(20);
		settle();
		load_settings(rise);
		offer(16'd400, 1'b0, 32'd8000);
		offer(16'd420, 1'b0, 32'd8001);
		offer(16'd700, 1'b0, 32'd8002);
		offer(16'd500, 1'b0, 32'd8003);
		offer(16'd310, 1'b0, 32'd8004);
		offer(16'd500, 1'b0, 32'd8005);
		offer(16'd50, 1'b0, 32'd8006);
		offer(16'd50, 1'b0, 32'd8006);

		plan[0] = CfgReset;
		plan[1] = '0;
		plan[2] = '1;
		for (int k = 3; k < 7; k++)
			plan[k] = roll_cfg();

		for (int k = 0; k < 7; k++) begin
			settle();
			load_settings(plan[k]);
			stamp = (k == 6) ? 32'hFFFF_F000 : StampW'($urandom);
			quiet = (k == 5);
			if (k == 3)
				hold_req = 1'b1;
			goal = sent + PhaseItems;
			while (sent < goal - PhaseItems / 2)
				motion();
			if (k == 4)
				settle();
			while (sent < goal)
				motion();
		end
		quiet = 1'b0;
		settle();

		if (mismatch_count == 0 && codes_owed == 0)
			$display("proximity_gesture_classifier: match");
		else
			$display("proximity_gesture_classifier: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("proximity_gesture_classifier: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pgc_pkg.sv
rtl/pgc_if.sv
rtl/pgc_cfg_regs.sv
rtl/pgc_core.sv
rtl/proximity_gesture_classifier.sv
dv/pgc_gesture_checker.sv
dv/tb_proximity_gesture_classifier.sv
